[sv/sdtm_pkg.sv]
package sdtm_pkg;

  // default sizes of the sample path
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int MAX_FACTOR_DEF   = 256;

  // configuration port
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 2'd1;

  // depth of the job queue between front and back
  localparam int JOB_DEPTH = 4;

  typedef enum logic [1:0] {
    MODE_SUBSAMPLE = 2'd0,
    MODE_MEAN      = 2'd1,
    MODE_PEAK      = 2'd2,
    MODE_NONE      = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    JOB_PASS = 2'd0,
    JOB_MEAN = 2'd1,
    JOB_PEAK = 2'd2
  } job_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE   = 2'd0,
    BK_DIV    = 2'd1,
    BK_DONE   = 2'd2,
    BK_SECOND = 2'd3
  } back_state_t;

endpackage

[sv/sdtm_queue.sv]
module sdtm_queue
  import sdtm_pkg::*;
#(
  parameter int W     = 8,
  parameter int DEPTH = JOB_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  output logic         full,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_wr, do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;

  // advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // store entry
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

[sv/sdtm_front.sv]
module sdtm_front
  import sdtm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int MAX_FACTOR   = MAX_FACTOR_DEF,
  localparam int FW    = $clog2(MAX_FACTOR) + 1,
  localparam int SUMW  = SAMPLE_WIDTH + $clog2(MAX_FACTOR),
  localparam int JOB_W = 32 + SUMW + 2 * SAMPLE_WIDTH + FW + 1 + 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [31:0]                    in_x_position,
  input  logic signed [SAMPLE_WIDTH-1:0] in_y_sample,
  input  logic                           in_sample_valid,
  input  logic                           in_set_end,
  output logic                           job_push,
  output logic [JOB_W-1:0]               job_data,
  input  logic                           job_full
);

  localparam int IW = $clog2(MAX_FACTOR);
  localparam int SW = SAMPLE_WIDTH;

  logic [CFG_W-1:0]        factor_r, factor_nxt;
  mode_t                   mode_r, mode_nxt;
  logic [IW-1:0]           idx_r, idx_nxt;
  logic signed [SUMW-1:0]  sum_r, sum_nxt;
  logic signed [SW-1:0]    max_r, max_nxt;
  logic signed [SW-1:0]    min_r, min_nxt;
  logic                    inv_r, inv_nxt;
  logic [31:0]             mid_r, mid_nxt;

  logic [FW-1:0]           f_eff;
  logic                    accept, bypass, first, last_in_blk;
  logic signed [SUMW-1:0]  y_ext;
  logic signed [SW-1:0]    y_kept;
  job_kind_t               kind;
  logic                    gen, ok;
  logic [31:0]             j_pos;
  logic [SW-1:0]           j_hi, j_lo;

  assign accept  = in_push && !job_full;
  assign in_full = job_full;

  // clamp factor: zero acts as one, large values saturate
  always_comb begin
    if (factor_r == '0) begin
      f_eff = FW'(1);
    end else if (32'(factor_r) > MAX_FACTOR) begin
      f_eff = FW'(MAX_FACTOR);
    end else begin
      f_eff = FW'(factor_r);
    end
  end

  assign bypass      = (f_eff == FW'(1)) || (mode_r == MODE_NONE);
  assign first       = (idx_r == '0);
  assign last_in_blk = ({1'b0, idx_r} + 1'b1) == f_eff;
  assign y_ext       = {{(SUMW - SW){in_y_sample[SW-1]}}, in_y_sample};
  assign y_kept      = in_sample_valid ? in_y_sample : '0;

  // accumulate block and classify the request
  always_comb begin
    factor_nxt = factor_r;
    mode_nxt   = mode_r;
    idx_nxt    = idx_r;
    sum_nxt    = sum_r;
    max_nxt    = max_r;
    min_nxt    = min_r;
    inv_nxt    = inv_r;
    mid_nxt    = mid_r;
    gen        = 1'b0;
    kind       = JOB_PASS;
    ok         = in_sample_valid;
    j_pos      = in_x_position;
    j_hi       = y_kept;
    j_lo       = '0;

    if (cfg_we) begin
      priority case (cfg_index)
        CFG_IDX_FACTOR: begin
          factor_nxt = cfg_data;
          idx_nxt    = '0;
        end
        CFG_IDX_MODE: begin
          mode_nxt = mode_t'(cfg_data[1:0]);
          idx_nxt  = '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      if (bypass) begin
        gen = 1'b1;
        if (in_set_end) begin
          idx_nxt = '0;
        end
      end else begin
        sum_nxt = (first ? '0 : sum_r) + y_ext;
        max_nxt = (first || in_y_sample > max_r) ? in_y_sample : max_r;
        min_nxt = (first || in_y_sample < min_r) ? in_y_sample : min_r;
        inv_nxt = (first ? 1'b0 : inv_r) | !in_sample_valid;
        if ({1'b0, idx_r} == (f_eff >> 1)) begin
          mid_nxt = in_x_position;
        end
        if (first && mode_r == MODE_SUBSAMPLE) begin
          gen = 1'b1;
        end
        if (last_in_blk) begin
          idx_nxt = '0;
          ok      = !inv_nxt;
          j_pos   = mid_nxt;
          j_hi    = max_nxt;
          j_lo    = min_nxt;
          unique case (mode_r)
            MODE_MEAN: begin
              gen  = 1'b1;
              kind = JOB_MEAN;
            end
            MODE_PEAK: begin
              gen  = 1'b1;
              kind = JOB_PEAK;
            end
            MODE_SUBSAMPLE, MODE_NONE: ;
          endcase
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
        if (in_set_end) begin
          idx_nxt = '0;
        end
      end
    end
  end

  assign job_push = accept && gen && !cfg_we;
  assign job_data = {j_pos, sum_nxt, j_hi, j_lo, f_eff, ok, kind};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= CFG_W'(1);
      mode_r   <= MODE_SUBSAMPLE;
      idx_r    <= '0;
    end else begin
      factor_r <= factor_nxt;
      mode_r   <= mode_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // hold block accumulators
  always_ff @(posedge clk) begin
    sum_r <= sum_nxt;
    max_r <= max_nxt;
    min_r <= min_nxt;
    inv_r <= inv_nxt;
    mid_r <= mid_nxt;
  end

endmodule

[sv/sdtm_back.sv]
module sdtm_back
  import sdtm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int MAX_FACTOR   = MAX_FACTOR_DEF,
  localparam int FW    = $clog2(MAX_FACTOR) + 1,
  localparam int SUMW  = SAMPLE_WIDTH + $clog2(MAX_FACTOR),
  localparam int JOB_W = 32 + SUMW + 2 * SAMPLE_WIDTH + FW + 1 + 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           job_empty,
  input  logic [JOB_W-1:0]               job_data,
  output logic                           job_pop,
  input  logic                           out_pop,
  output logic                           out_empty,
  output logic [31:0]                    out_position,
  output logic signed [SAMPLE_WIDTH-1:0] out_value,
  output logic                           out_valid,
  output logic                           out_last_of_run
);

  localparam int SW   = SAMPLE_WIDTH;
  localparam int CNTW = $clog2(SUMW);

  // unpack request
  logic [31:0]     j_pos;
  logic [SUMW-1:0] j_sum;
  logic [SW-1:0]   j_hi, j_lo;
  logic [FW-1:0]   j_factor;
  logic            j_ok;
  logic [1:0]      j_kind_raw;
  job_kind_t       j_kind;

  assign {j_pos, j_sum, j_hi, j_lo, j_factor, j_ok, j_kind_raw} = job_data;
  assign j_kind = job_kind_t'(j_kind_raw);

  back_state_t     state_r, state_nxt;
  logic [FW-1:0]   rem_r, rem_nxt;
  logic [SUMW-1:0] quo_r, quo_nxt;
  logic [FW-1:0]   div_r, div_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            neg_r, neg_nxt;
  logic            ok_r, ok_nxt;
  logic [31:0]     pos_r, pos_nxt;
  logic [SW-1:0]   min_r, min_nxt;

  logic            ov_r, ov_nxt;
  logic [31:0]     opos_r, opos_nxt;
  logic [SW-1:0]   oval_r, oval_nxt;
  logic            ovld_r, ovld_nxt;
  logic            olast_r, olast_nxt;

  logic            out_free;
  logic [FW:0]     shifted, diff;
  logic            ge;
  logic [SUMW-1:0] quo_signed;

  assign out_free   = !ov_r || out_pop;
  assign shifted    = {rem_r, quo_r[SUMW-1]};
  assign diff       = shifted - {1'b0, div_r};
  assign ge         = shifted >= {1'b0, div_r};
  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;

  // sequence requests, divide one bit a cycle, fill the output register
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    div_nxt   = div_r;
    cnt_nxt   = cnt_r;
    neg_nxt   = neg_r;
    ok_nxt    = ok_r;
    pos_nxt   = pos_r;
    min_nxt   = min_r;
    ov_nxt    = ov_r && !out_pop;
    opos_nxt  = opos_r;
    oval_nxt  = oval_r;
    ovld_nxt  = ovld_r;
    olast_nxt = olast_r;
    job_pop   = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (!job_empty) begin
          unique case (j_kind)
            JOB_MEAN: begin
              job_pop   = 1'b1;
              neg_nxt   = j_sum[SUMW-1];
              quo_nxt   = j_sum[SUMW-1] ? (~j_sum + 1'b1) : j_sum;
              rem_nxt   = '0;
              div_nxt   = j_factor;
              cnt_nxt   = CNTW'(SUMW - 1);
              ok_nxt    = j_ok;
              pos_nxt   = j_pos;
              state_nxt = BK_DIV;
            end
            JOB_PEAK: begin
              if (out_free) begin
                job_pop   = 1'b1;
                ov_nxt    = 1'b1;
                opos_nxt  = j_pos;
                oval_nxt  = j_ok ? j_hi : '0;
                ovld_nxt  = j_ok;
                olast_nxt = 1'b0;
                pos_nxt   = j_pos;
                ok_nxt    = j_ok;
                min_nxt   = j_ok ? j_lo : '0;
                state_nxt = BK_SECOND;
              end
            end
            default: begin
              if (out_free) begin
                job_pop   = 1'b1;
                ov_nxt    = 1'b1;
                opos_nxt  = j_pos;
                oval_nxt  = j_hi;
                ovld_nxt  = j_ok;
                olast_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      BK_DIV: begin
        rem_nxt = ge ? diff[FW-1:0] : shifted[FW-1:0];
        quo_nxt = {quo_r[SUMW-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          opos_nxt  = pos_r;
          oval_nxt  = ok_r ? quo_signed[SW-1:0] : '0;
          ovld_nxt  = ok_r;
          olast_nxt = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      BK_SECOND: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          opos_nxt  = pos_r;
          oval_nxt  = min_r;
          ovld_nxt  = ok_r;
          olast_nxt = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // hold divider and result payload
  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    div_r   <= div_nxt;
    cnt_r   <= cnt_nxt;
    neg_r   <= neg_nxt;
    ok_r    <= ok_nxt;
    pos_r   <= pos_nxt;
    min_r   <= min_nxt;
    opos_r  <= opos_nxt;
    oval_r  <= oval_nxt;
    ovld_r  <= ovld_nxt;
    olast_r <= olast_nxt;
  end

  assign out_empty       = !ov_r;
  assign out_position    = opos_r;
  assign out_value       = oval_r;
  assign out_valid       = ovld_r;
  assign out_last_of_run = olast_r;

endmodule

[sv/sample_decimator_three_mode.sv]
// Decimator for a stream of (position, sample) pairs with subsample, mean and
// peak (max then min) modes.
// Input: drive in_* and raise in_push; the pair is taken on a clock edge where
// in_full is low. Results: while out_empty is low the oldest result sits on
// out_*; raise out_pop to take it.
// Configuration: cfg_we with cfg_index 0 (factor) or 1 (mode) and cfg_data;
// a write to either restarts the current block. Write only while the block is idle.
// Path: each request passes through the request queue to the back end, which
// fills the output register. The mean comes from a restoring divider that
// retires one quotient bit per cycle; the back end takes no new request until
// the mean result is in the output register. A peak block yields two results,
// its max and then its min.
// Throughput: one pair per cycle on the input while in_full is low. A
// four-entry request queue between the classifier and the divider absorbs
// short bursts.
// When out_pop stays low the output register holds, the request queue fills
// and in_full rises; nothing is dropped.
// Reset (rst_n low at a clock edge) sets factor 1, mode subsample, and empties
// the queue and the output register.
module sample_decimator_three_mode
  import sdtm_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int MAX_FACTOR   = MAX_FACTOR_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic [31:0]                    in_x_position,
  input  logic signed [SAMPLE_WIDTH-1:0] in_y_sample,
  input  logic                           in_sample_valid,
  input  logic                           in_set_end,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [31:0]                    out_position,
  output logic signed [SAMPLE_WIDTH-1:0] out_value,
  output logic                           out_valid,
  output logic                           out_last_of_run
);

  localparam int FW    = $clog2(MAX_FACTOR) + 1;
  localparam int SUMW  = SAMPLE_WIDTH + $clog2(MAX_FACTOR);
  localparam int JOB_W = 32 + SUMW + 2 * SAMPLE_WIDTH + FW + 1 + 2;

  logic             job_push, job_full, job_pop, job_empty;
  logic [JOB_W-1:0] job_wdata, job_rdata;

  // classify pairs and build block requests
  sdtm_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .MAX_FACTOR  (MAX_FACTOR)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_x_position  (in_x_position),
    .in_y_sample    (in_y_sample),
    .in_sample_valid(in_sample_valid),
    .in_set_end     (in_set_end),
    .job_push       (job_push),
    .job_data       (job_wdata),
    .job_full       (job_full)
  );

  // buffer requests between front and back
  sdtm_queue #(
    .W    (JOB_W),
    .DEPTH(JOB_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_push),
    .wr_data(job_wdata),
    .full   (job_full),
    .rd_en  (job_pop),
    .rd_data(job_rdata),
    .empty  (job_empty)
  );

  // divide, split peak pairs and hold the result
  sdtm_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .MAX_FACTOR  (MAX_FACTOR)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job_empty      (job_empty),
    .job_data       (job_rdata),
    .job_pop        (job_pop),
    .out_pop        (out_pop),
    .out_empty      (out_empty),
    .out_position   (out_position),
    .out_value      (out_value),
    .out_valid      (out_valid),
    .out_last_of_run(out_last_of_run)
  );

endmodule

[bench/tb_sample_decimator_three_mode.sv]
`timescale 1ns / 100ps

import sdtm_pkg::*;

// One sample request as driven on the in_ ports
typedef struct {
  logic [31:0]                        x;
  logic signed [SAMPLE_WIDTH_DEF-1:0] y;
  logic                               ok;
  logic                               set_end;
} sample_req_t;

// One decimated point as seen on the out_ ports
typedef struct {
  logic [31:0]                        pos;
  logic signed [SAMPLE_WIDTH_DEF-1:0] value;
  logic                               ok;
  logic                               last;
} decim_point_t;

// Tracks the block state and the decimated points still to come
class decimation_tracker;
  logic [CFG_W-1:0] factor_reg;
  mode_t            mode_reg;
  int               blk_idx;
  longint           blk_sum;
  longint           blk_max;
  longint           blk_min;
  bit               blk_bad;
  logic [31:0]      mid_pos;
  decim_point_t     awaited_points[$];
  int               mismatches;
  int               points_seen;

  function new();
    factor_reg  = 9'd1;
    mode_reg    = MODE_SUBSAMPLE;
    mismatches  = 0;
    points_seen = 0;
    clear_block();
  endfunction

  function void clear_block();
    blk_idx = 0;
    blk_sum = 0;
    blk_max = 0;
    blk_min = 0;
    blk_bad = 1'b0;
    mid_pos = '0;
  endfunction

  // Zero and oversized factors fold onto the supported range
  function int eff_factor();
    int f;
    f = int'(factor_reg);
    if (f == 0) f = 1;
    if (f > MAX_FACTOR_DEF) f = MAX_FACTOR_DEF;
    return f;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    if (idx == CFG_IDX_FACTOR) begin
      factor_reg = data;
      clear_block();
    end else if (idx == CFG_IDX_MODE) begin
      mode_reg = mode_t'(data[1:0]);
      clear_block();
    end
  endfunction

  function void add_point(logic [31:0] pos, longint val, bit ok, bit last);
    decim_point_t p;
    p.pos   = pos;
    p.value = ok ? val[SAMPLE_WIDTH_DEF-1:0] : '0;
    p.ok    = ok;
    p.last  = last;
    awaited_points = {awaited_points, p};
  endfunction

  // Advance the block state by one accepted request
  function void note_sample(sample_req_t r);
    int     f;
    longint y;
    f = eff_factor();
    y = longint'(r.y);
    // pass through: one point per request
    if (f == 1 || mode_reg == MODE_NONE) begin
      add_point(r.x, y, r.ok, 1'b1);
      if (r.set_end) clear_block();
      return;
    end
    if (blk_idx >= f) clear_block();
    if (blk_idx == 0) begin
      blk_sum = 0;
      blk_max = y;
      blk_min = y;
      blk_bad = 1'b0;
      if (mode_reg == MODE_SUBSAMPLE) add_point(r.x, y, r.ok, 1'b1);
    end else begin
      if (y > blk_max) blk_max = y;
      if (y < blk_min) blk_min = y;
    end
    blk_sum += y;
    if (!r.ok) blk_bad = 1'b1;
    if (blk_idx == f / 2) mid_pos = r.x;
    // close the block
    if (blk_idx + 1 == f) begin
      if (mode_reg == MODE_MEAN) begin
        add_point(mid_pos, blk_sum / longint'(f), !blk_bad, 1'b1);
      end else if (mode_reg == MODE_PEAK) begin
        add_point(mid_pos, blk_max, !blk_bad, 1'b0);
        add_point(mid_pos, blk_min, !blk_bad, 1'b1);
      end
      clear_block();
    end else begin
      blk_idx++;
    end
    if (r.set_end) clear_block();
  endfunction

  function void check_point(decim_point_t got);
    decim_point_t want;
    points_seen++;
    if (awaited_points.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("ERROR: point %0d pos=%h value=%0d valid=%b last=%b arrived unexpected",
                 points_seen, got.pos, got.value, got.ok, got.last);
      return;
    end
    want = awaited_points.pop_front();
    if (got.pos !== want.pos || got.value !== want.value ||
        got.ok !== want.ok || got.last !== want.last) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("ERROR: point %0d expected pos=%h value=%0d valid=%b last=%b",
                 points_seen, want.pos, want.value, want.ok, want.last);
        $display("       got pos=%h value=%0d valid=%b last=%b",
                 got.pos, got.value, got.ok, got.last);
      end
    end
  endfunction

  function int pending();
    return awaited_points.size();
  endfunction
endclass

module tb_sample_decimator_three_mode;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;
  localparam int SETTLE_CYCLES = 64;
  localparam int ITEM_TARGET   = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]               cfg_index = '0;
  logic [CFG_W-1:0]                   cfg_data = '0;
  logic                               in_push = 1'b0;
  logic                               in_full;
  logic [31:0]                        in_x_position = '0;
  logic signed [SAMPLE_WIDTH_DEF-1:0] in_y_sample = '0;
  logic                               in_sample_valid = 1'b0;
  logic                               in_set_end = 1'b0;
  logic                               out_empty;
  logic                               out_pop = 1'b0;
  logic [31:0]                        out_position;
  logic signed [SAMPLE_WIDTH_DEF-1:0] out_value;
  logic                               out_valid;
  logic                               out_last_of_run;

  decimation_tracker tracker = new();
  decim_point_t      popped;
  bit                no_gaps = 1'b0;
  int                pop_hold = 0;
  int                cycle_count = 0;
  int                items_sent = 0;

  sample_decimator_three_mode i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_x_position   (in_x_position),
    .in_y_sample     (in_y_sample),
    .in_sample_valid (in_sample_valid),
    .in_set_end      (in_set_end),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_position    (out_position),
    .out_value       (out_value),
    .out_valid       (out_valid),
    .out_last_of_run (out_last_of_run)
  );

  always #1 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int rand_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_req_t mk_req(logic [31:0] x, int y, bit ok, bit last_in_set);
    sample_req_t r;
    r.x       = x;
    r.y       = y[SAMPLE_WIDTH_DEF-1:0];
    r.ok      = ok;
    r.set_end = last_in_set;
    return r;
  endfunction

  function automatic sample_req_t rand_req(bit close_set);
    sample_req_t r;
    int          pick;
    pick      = $urandom_range(0, 9);
    r.x       = $urandom;
    r.y       = (pick == 0) ? 16'sh8000 : (pick == 1) ? 16'sh7FFF :
                (pick == 2) ? 16'sh0000 : 16'($urandom);
    r.ok      = ($urandom_range(0, 15) != 0);
    r.set_end = close_set || ($urandom_range(0, 24) == 0);
    return r;
  endfunction

  // Drive one request and hold it until it is taken
  task automatic send_item(sample_req_t r);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_push = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_push         = 1'b1;
    in_x_position   = r.x;
    in_y_sample     = r.y;
    in_sample_valid = r.ok;
    in_set_end      = r.set_end;
    @(posedge clk);
    while (in_full) @(posedge clk);
    tracker.note_sample(r);
    items_sent++;
  endtask

  // Drain every awaited point, then let the divider settle
  task automatic wait_idle();
    @(negedge clk);
    in_push = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    tracker.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Pop side: random stalls between takes
  always @(negedge clk) begin
    if (pop_hold > 0) begin
      out_pop  = 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      out_pop  = 1'b1;
      pop_hold = rand_gap();
    end
  end

  // Check each popped point
  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      popped.pos   = out_position;
      popped.value = out_value;
      popped.ok    = out_valid;
      popped.last  = out_last_of_run;
      tracker.check_point(popped);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int          what;
    int          pick;
    int          n_items;
    int          big_phases;
    logic [8:0]  fac;
    big_phases = 0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // pass through at reset settings: field extremes, missing sample, set end
    send_item(mk_req(32'h0000_0000, -32768, 1'b1, 1'b0));
    send_item(mk_req(32'hFFFF_FFFF, 32767, 1'b1, 1'b0));
    send_item(mk_req(32'h5555_AAAA, -1, 1'b0, 1'b1));

    // factor zero folds to pass through
    wait_idle();
    write_reg(CFG_IDX_FACTOR, 9'd0);
    write_reg(CFG_IDX_MODE, CFG_W'(MODE_MEAN));
    send_item(mk_req(32'hAAAA_5555, 1234, 1'b1, 1'b0));

    // mode none ignores the factor
    wait_idle();
    write_reg(CFG_IDX_FACTOR, 9'd3);
    write_reg(CFG_IDX_MODE, CFG_W'(MODE_NONE));
    send_item(mk_req(32'd2, -5, 1'b1, 1'b0));

    // subsample: first of each block, partial block closed by set end
    wait_idle();
    write_reg(CFG_IDX_MODE, CFG_W'(MODE_SUBSAMPLE));
    send_item(mk_req(32'd10, 11, 1'b1, 1'b0));
    send_item(mk_req(32'd11, 12, 1'b1, 1'b0));
    send_item(mk_req(32'd12, 13, 1'b1, 1'b0));
    send_item(mk_req(32'd13, -14, 1'b0, 1'b1));

    // mean: truncation toward zero, then a block with a missing sample
    wait_idle();
    write_reg(CFG_IDX_FACTOR, 9'd2);
    write_reg(CFG_IDX_MODE, CFG_W'(MODE_MEAN));
    send_item(mk_req(32'd20, -32768, 1'b1, 1'b0));
    send_item(mk_req(32'd21, -32767, 1'b1, 1'b0));
    send_item(mk_req(32'd22, 7, 1'b0, 1'b0));
    send_item(mk_req(32'd23, 8, 1'b1, 1'b0));

    // partial mean block dropped at set end
    wait_idle();
    write_reg(CFG_IDX_FACTOR, 9'd3);
    send_item(mk_req(32'd30, 100, 1'b1, 1'b0));
    send_item(mk_req(32'd31, 200, 1'b1, 1'b1));

    // out-of-range register writes leave a partial block alone
    send_item(mk_req(32'd40, 9, 1'b1, 1'b0));
    send_item(mk_req(32'd41, 9, 1'b1, 1'b0));
    wait_idle();
    write_reg(CFG_IDX_SPARE_LO, 9'h1FF);
    write_reg(CFG_IDX_SPARE_HI, 9'h155);
    send_item(mk_req(32'd42, 9, 1'b1, 1'b0));

    // peak: extremes, then a block marked invalid
    wait_idle();
    write_reg(CFG_IDX_FACTOR, 9'd2);
    write_reg(CFG_IDX_MODE, CFG_W'(MODE_PEAK));
    send_item(mk_req(32'd50, 32767, 1'b1, 1'b0));
    send_item(mk_req(32'd51, -32768, 1'b1, 1'b0));
    wait_idle();
    write_reg(CFG_IDX_FACTOR, 9'd3);
    send_item(mk_req(32'd60, 5, 1'b1, 1'b0));
    send_item(mk_req(32'd61, -7, 1'b0, 1'b0));
    send_item(mk_req(32'd62, 3, 1'b1, 1'b0));

    // random phases, each with its own settings
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      no_gaps = ($urandom_range(0, 4) == 0);
      what    = $urandom_range(0, 7);
      if (what <= 2 && tracker.eff_factor() >= 64) what = 3;
      if (what == 1) begin
        write_reg(($urandom_range(0, 1) != 0) ? CFG_IDX_SPARE_LO : CFG_IDX_SPARE_HI,
                  9'($urandom));
      end else if (what == 2) begin
        write_reg(CFG_IDX_MODE, 9'($urandom_range(0, 3)));
      end else if (what >= 3) begin
        pick = $urandom_range(0, 15);
        if (pick == 0)
          fac = 9'd1;
        else if (pick == 1)
          fac = 9'd0;
        else if (pick == 2 && big_phases < 2)
          fac = 9'($urandom_range(257, 511));
        else if (pick == 3 && big_phases < 2)
          fac = 9'd256;
        else
          fac = 9'($urandom_range(2, 9));
        write_reg(CFG_IDX_FACTOR, fac);
        write_reg(CFG_IDX_MODE, 9'($urandom_range(0, 3)));
      end
      // large blocks get one full block and a little more
      if (tracker.eff_factor() >= 64) begin
        big_phases++;
        n_items = tracker.eff_factor() + $urandom_range(0, 20);
      end else begin
        n_items = $urandom_range(5, 40);
      end
      for (int k = 0; k < n_items; k++)
        send_item(rand_req((k == n_items - 1) && ($urandom_range(0, 2) == 0)));
    end

    // drain and settle
    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
